// ----- src/dsh_pkg.sv -----
// shared constants, state codes and helpers of the diamond-square height generator
package dsh_pkg;

	localparam int MAX_GRID_LOG2 = 6;
	localparam int COORD_W = MAX_GRID_LOG2 + 1;
	localparam int GRID_STRIDE = (1 << MAX_GRID_LOG2) + 1;
	localparam int GRID_DEPTH = GRID_STRIDE * GRID_STRIDE;
	localparam int ADDR_W = $clog2(GRID_DEPTH);
	localparam int H_W = 18;
	localparam int SUM_W = H_W + 2;
	localparam int MAXH_W = 15;
	localparam int SAMPLE_W = 16;

	// generation phases
	localparam logic [1:0] PH_CORNER = 2'd0;
	localparam logic [1:0] PH_SQUARE = 2'd1;
	localparam logic [1:0] PH_DIAM_C = 2'd2;
	localparam logic [1:0] PH_DIAM_R = 2'd3;

	// register indexes
	localparam logic REG_GRID_LOG2 = 1'b0;
	localparam logic REG_MAX_HEIGHT = 1'b1;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// column-major grid address
	function automatic addr_t cell_addr(input coord_t c, input coord_t r);
		logic [ADDR_W-1:0] cw;
		cw = ADDR_W'(c);
		return addr_t'(cw * ADDR_W'(GRID_STRIDE)) + ADDR_W'(r);
	endfunction

endpackage

// ----- src/dsh_mean.sv -----
// neighbour mean: divide a signed sum by four or by three, truncating toward zero
module dsh_mean import dsh_pkg::*; (
	input  logic                    clk,
	input  logic signed [SUM_W-1:0] sum,
	input  logic                    by_three,
	output logic signed [H_W-1:0]   mean_q
);
	localparam logic [19:0] RECIP3 = 20'd174763;

	logic                    neg;
	logic [SUM_W-1:0]        mag;
	logic [SUM_W+19:0]       prod;
	logic [SUM_W-1:0]        quo3;
	logic [SUM_W-1:0]        quo4;
	logic [SUM_W-1:0]        quo;

	// magnitude path keeps truncation toward zero
	always_comb begin
		neg  = sum[SUM_W-1];
		mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
		prod = (SUM_W+20)'(mag) * (SUM_W+20)'(RECIP3);
		quo3 = SUM_W'(prod >> 19);
		quo4 = mag >> 2;
		quo  = by_three ? quo3 : quo4;
	end

	always_ff @(posedge clk) begin
		mean_q <= neg ? H_W'(-quo) : H_W'(quo);
	end

endmodule

// ----- src/diamond_square_heightmap_top.sv -----
// top level of the diamond-square height generator with its grid memory
// Each accepted random sample produces the next grid point of a (2^k+1)^2 diamond-square
// grid; the first sample also emits the two fixed top corners, so it yields three points.
// A square or diamond point takes its sample, then four neighbour read slots on the one grid
// memory read port and a wait for the read data, then the mean, then the height write-back
// and output register load; a held output stalls that last step, and no new sample is taken
// until it is done. The first sample emits its three corners in turn. Writing grid_log2
// restarts generation; after the last point (tlast high) further samples are taken and
// dropped. The grid needs no clearing.
module diamond_square_heightmap_top import dsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // random_sample[15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // column[6:0], row[13:7], point_height[31:14]
	output logic        m_tlast,   // final_point
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_MEAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;
	localparam int CW1 = COORD_W + 1;

	logic [1:0]              st_q;
	logic [MAXH_W-1:0]       maxh_q;
	coord_t                  edge_q, span_q, col_q, row_q;
	logic [1:0]              phase_q;
	logic [2:0]              iter_q;
	logic                    done_q;
	logic [2:0]              k_q;
	logic [3:0]              nv_q;
	logic                    rd_pend_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [H_W-1:0]   rnd_q;
	logic signed [H_W-1:0]   mean_q;
	logic                    ov_q, olast_q;
	logic [31:0]             odata_q;

	logic [H_W-1:0]          mem [GRID_DEPTH];
	logic [H_W-1:0]          rdata_q;

	coord_t                  half;
	logic                    s_acc, out_free;
	logic [2:0]              eff_log;
	logic signed [31:0]      prod;
	logic signed [31:0]      rnd_full;
	logic [CW1-1:0]          c1, r1, nh, ch, rh, cs, rs, sp;
	coord_t                  rd_c, rd_r;
	logic                    rd_en;
	coord_t                  em_c, em_r;
	logic signed [H_W+2:0]   em_sum;
	logic signed [H_W-1:0]   em_h;
	logic                    em_last_of_item;
	logic                    fin;
	logic [3:0]              nv_new;

	assign half     = span_q >> 1;
	assign s_tready = (st_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !ov_q || m_tready;
	assign m_tvalid = ov_q;
	assign m_tdata  = odata_q;
	assign m_tlast  = olast_q;

	// effective grid size from the written register value
	always_comb begin
		eff_log = cfg_data[2:0];
		if (cfg_data[2:0] == 3'd0) eff_log = 3'd1;
		if (cfg_data[2:0] > 3'(MAX_GRID_LOG2)) eff_log = 3'(MAX_GRID_LOG2);
	end

	// random term, floor shifted by 15 plus the iteration count
	always_comb begin
		prod     = 32'($signed(s_tdata)) * $signed({17'd0, maxh_q});
		rnd_full = prod >>> (5'd15 + 5'(iter_q));
	end

	// widened cursor arithmetic
	assign c1 = CW1'(col_q);
	assign r1 = CW1'(row_q);
	assign nh = CW1'(edge_q);
	assign sp = CW1'(span_q);
	assign ch = CW1'(half);
	assign rh = ch;
	assign cs = c1 + sp;
	assign rs = r1 + sp;

	// neighbour presence: all four in the square pass, bounds-checked in the diamond passes
	always_comb begin
		if (phase_q == PH_SQUARE) begin
			nv_new = 4'b1111;
		end else begin
			nv_new[0] = (c1 >= ch);
			nv_new[1] = (c1 + ch <= nh);
			nv_new[2] = (r1 >= rh);
			nv_new[3] = (r1 + rh <= nh);
		end
	end

	// neighbour read address
	always_comb begin
		rd_c = col_q;
		rd_r = row_q;
		if (phase_q == PH_SQUARE) begin
			case (k_q[1:0])
				2'd0: begin rd_c = col_q; rd_r = row_q; end
				2'd1: begin rd_c = col_q; rd_r = COORD_W'(rs); end
				2'd2: begin rd_c = COORD_W'(cs); rd_r = row_q; end
				default: begin rd_c = COORD_W'(cs); rd_r = COORD_W'(rs); end
			endcase
		end else begin
			case (k_q[1:0])
				2'd0: rd_c = COORD_W'(c1 - ch);
				2'd1: rd_c = COORD_W'(c1 + ch);
				2'd2: rd_r = COORD_W'(r1 - rh);
				default: rd_r = COORD_W'(r1 + rh);
			endcase
		end
		rd_en = (st_q == ST_READ) && !k_q[2] && nv_q[k_q[1:0]];
	end

	// point to emit and its height
	always_comb begin
		em_c = col_q;
		em_r = row_q;
		em_sum = (H_W+3)'(mean_q) + (H_W+3)'(rnd_q);
		em_last_of_item = 1'b1;
		if (phase_q == PH_CORNER) begin
			em_sum = (H_W+3)'(rnd_q);
			if (col_q == '0) begin
				em_last_of_item = (k_q == 3'd2);
				case (k_q[1:0])
					2'd0: begin
						em_c = '0; em_r = '0;
						em_sum = (H_W+3)'($signed({1'b0, maxh_q}));
					end
					2'd1: begin
						em_c = edge_q; em_r = '0;
						em_sum = -(H_W+3)'($signed({1'b0, maxh_q}));
					end
					default: begin em_c = '0; em_r = edge_q; end
				endcase
			end else begin
				em_c = edge_q; em_r = edge_q;
			end
		end else if (phase_q == PH_SQUARE) begin
			em_c = col_q + half;
			em_r = row_q + half;
		end
		if (em_sum > (H_W+3)'(131071)) em_h = 18'sd131071;
		else if (em_sum < -(H_W+3)'(131072)) em_h = -18'sd131072;
		else em_h = H_W'(em_sum);
	end

	assign fin = (phase_q == PH_DIAM_R) && (rs > nh) && (cs > nh) && (half <= 7'd1);

	// grid memory
	always_ff @(posedge clk) begin
		if (st_q == ST_EMIT && out_free) mem[cell_addr(em_c, em_r)] <= em_h;
		if (rd_en) rdata_q <= mem[cell_addr(rd_c, rd_r)];
	end

	dsh_mean u_mean (
		.clk      (clk),
		.sum      (sum_q),
		.by_three (!(&nv_q)),
		.mean_q   (mean_q)
	);

	// sample payload
	always_ff @(posedge clk) begin
		if (s_acc) rnd_q <= H_W'(rnd_full);
		if (st_q == ST_IDLE) sum_q <= '0;
		else if (st_q == ST_READ && rd_pend_q)
			sum_q <= sum_q + SUM_W'($signed(rdata_q));
		if (st_q == ST_EMIT && out_free)
			odata_q <= {em_h, em_r, em_c};
	end

	// sequencer, cursor and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			maxh_q    <= 15'd1024;
			edge_q    <= COORD_W'(1 << MAX_GRID_LOG2);
			span_q    <= COORD_W'(1 << MAX_GRID_LOG2);
			phase_q   <= PH_CORNER;
			col_q     <= '0;
			row_q     <= '0;
			iter_q    <= '0;
			done_q    <= 1'b0;
			k_q       <= '0;
			nv_q      <= '0;
			rd_pend_q <= 1'b0;
			ov_q      <= 1'b0;
			olast_q   <= 1'b0;
		end else begin
			// output register valid
			if (st_q == ST_EMIT && out_free) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
			rd_pend_q <= rd_en;
			case (st_q)
				ST_IDLE: begin
					if (s_acc && !done_q) begin
						k_q  <= '0;
						nv_q <= nv_new;
						st_q <= (phase_q == PH_CORNER) ? ST_EMIT : ST_READ;
					end
				end
				ST_READ: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) st_q <= ST_MEAN;
				end
				ST_MEAN: begin
					k_q  <= '0;
					st_q <= ST_EMIT;
				end
				default: begin
					if (out_free) begin
						olast_q <= fin;
						if (!em_last_of_item) begin
							k_q <= k_q + 3'd1;
						end else begin
							st_q <= ST_IDLE;
							case (phase_q)
								PH_CORNER: begin
									if (col_q == '0) begin
										col_q <= edge_q;
									end else begin
										phase_q <= PH_SQUARE;
										col_q <= '0;
										row_q <= '0;
									end
								end
								PH_SQUARE: begin
									if (rs >= nh) begin
										row_q <= '0;
										if (cs >= nh) begin
											phase_q <= PH_DIAM_C;
											col_q <= half;
											iter_q <= iter_q + 3'd1;
										end else begin
											col_q <= COORD_W'(cs);
										end
									end else begin
										row_q <= COORD_W'(rs);
									end
								end
								PH_DIAM_C: begin
									if (rs > nh) begin
										if (cs > nh) begin
											phase_q <= PH_DIAM_R;
											col_q <= '0;
											row_q <= half;
										end else begin
											row_q <= '0;
											col_q <= COORD_W'(cs);
										end
									end else begin
										row_q <= COORD_W'(rs);
									end
								end
								default: begin
									if (rs > nh) begin
										if (cs > nh) begin
											col_q <= '0;
											row_q <= '0;
											if (half <= 7'd1) done_q <= 1'b1;
											else begin
												span_q <= half;
												phase_q <= PH_SQUARE;
											end
										end else begin
											row_q <= half;
											col_q <= COORD_W'(cs);
										end
									end else begin
										row_q <= COORD_W'(rs);
									end
								end
							endcase
						end
					end
				end
			endcase
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_LOG2: begin
						edge_q  <= COORD_W'(1) << eff_log;
						span_q  <= COORD_W'(1) << eff_log;
						phase_q <= PH_CORNER;
						col_q   <= '0;
						row_q   <= '0;
						iter_q  <= '0;
						done_q  <= 1'b0;
					end
					default: maxh_q <= cfg_data;
				endcase
			end
		end
	end

	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_READ |-> k_q <= 3'd4) else $error("read counter overran");
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == PH_DIAM_R) else $error("done outside last diamond pass");
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) && !$past(cfg_we) |-> ov_q && olast_q)
		else $error("completion without final point");
	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= 3'(MAX_GRID_LOG2)) else $error("iteration count out of range");

endmodule
